// ----- hdl/ccfd_pkg.sv -----
package ccfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CRC_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 6;
  localparam int IDX_W    = 5;
  localparam int DROP_W   = 32;
  localparam int CMP_W    = 16;

  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [BYTE_W-1:0] DELIM    = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_FF  = 8'hFF;

  localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

  typedef enum logic [1:0] {
    V_NONE,
    V_DROP,
    V_EMPTY,
    V_DATA
  } verdict_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_HOLD,
    E_RD,
    E_LOAD
  } emit_state_t;

  typedef struct packed {
    logic              valid;
    verdict_t          kind;
    logic [BYTE_W-1:0] ftype;
    logic [LEN_W-1:0]  len;
  } frame_t;

  // One byte through the CRC-16 register, most significant bit first.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {d, 8'h00};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/ccfd_in_if.sv -----
interface ccfd_in_if;
  import ccfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ----- hdl/ccfd_out_if.sv -----
interface ccfd_out_if;
  import ccfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   frame_type;
  logic [LEN_W-1:0]    payload_length;
  logic [BYTE_W-1:0]   payload_byte;
  logic [IDX_W-1:0]    byte_index;
  logic                last;
  logic [DROP_W-1:0]   dropped_count;

  modport source (output valid, output status, output frame_type, output payload_length,
                  output payload_byte, output byte_index, output last,
                  output dropped_count, input ready);
  modport sink (input valid, input status, input frame_type, input payload_length,
                input payload_byte, input byte_index, input last,
                input dropped_count, output ready);
endinterface

// ----- hdl/ccfd_ram.sv -----
module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- hdl/ccfd_dec.sv -----
module ccfd_dec #(
  parameter int MAX_PAYLOAD      = 32,
  parameter int ENCODED_CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic [ccfd_pkg::BYTE_W-1:0]         byte_in,
  input  logic [ccfd_pkg::CRC_W-1:0]          crc_init,
  output logic                                ram_we,
  output logic [$clog2(ENCODED_CAPACITY)-1:0] ram_waddr,
  output logic [ccfd_pkg::BYTE_W-1:0]         ram_wdata,
  output ccfd_pkg::frame_t                    frame
);
  import ccfd_pkg::*;

  localparam int AW = $clog2(ENCODED_CAPACITY);
  localparam int CW = $clog2(ENCODED_CAPACITY + 1);
  localparam logic [CW-1:0]    CAP_C = CW'(ENCODED_CAPACITY);
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_PAYLOAD);

  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BYTE_W-1:0] rem_r, rem_nxt;
  logic              ff_r, ff_nxt;
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] decl_r, decl_nxt;
  logic [BYTE_W-1:0] rxlo_r, rxlo_nxt;
  logic [BYTE_W-1:0] rxhi_r, rxhi_nxt;

  logic              emit;
  logic [BYTE_W-1:0] dbyte;
  logic [CMP_W-1:0]  wr_w, decl_w;
  logic              good;

  assign wr_w   = CMP_W'(wr_r);
  assign decl_w = CMP_W'(decl_r);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    ff_nxt    = ff_r;
    wr_nxt    = wr_r;
    crc_nxt   = crc_r;
    type_nxt  = type_r;
    decl_nxt  = decl_r;
    rxlo_nxt  = rxlo_r;
    rxhi_nxt  = rxhi_r;
    emit      = 1'b0;
    dbyte     = byte_in;
    if (acc) begin
      if (byte_in == DELIM) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        rem_nxt   = '0;
        ff_nxt    = 1'b0;
        wr_nxt    = '0;
      end else if (!ovf_r) begin
        if (count_r >= CAP_C) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CW'(1);
          if (rem_r == '0) begin
            // A code byte closes the previous group, which ends in a zero
            // unless it was a full group.
            emit    = (count_r != '0) && !ff_r;
            dbyte   = '0;
            rem_nxt = byte_in - BYTE_W'(1);
            ff_nxt  = (byte_in == CODE_FF);
          end else begin
            emit    = 1'b1;
            rem_nxt = rem_r - BYTE_W'(1);
          end
        end
      end
    end
    if (emit) begin
      wr_nxt = wr_r + AW'(1);
      if (wr_r == AW'(0)) begin
        type_nxt = dbyte;
      end
      if (wr_r == AW'(1)) begin
        decl_nxt = dbyte;
      end
      if (wr_r == AW'(0)) begin
        crc_nxt = crc16_byte(crc_init, dbyte);
      end else if (wr_w < decl_w + CMP_W'(2) || wr_r == AW'(1)) begin
        crc_nxt = crc16_byte(crc_r, dbyte);
      end
      if (wr_w == decl_w + CMP_W'(2)) begin
        rxlo_nxt = dbyte;
      end
      if (wr_w == decl_w + CMP_W'(3)) begin
        rxhi_nxt = dbyte;
      end
    end
  end

  assign ram_we    = emit;
  assign ram_waddr = wr_r;
  assign ram_wdata = dbyte;

  assign good = (rem_r == '0) && (wr_w >= CMP_W'(4)) && (wr_w == decl_w + CMP_W'(4))
              && (decl_w <= MAX_C) && ({rxhi_r, rxlo_r} == crc_r);

  always_comb begin
    frame.valid = acc && (byte_in == DELIM);
    frame.ftype = type_r;
    frame.len   = decl_r[LEN_W-1:0];
    if (ovf_r) begin
      frame.kind = V_DROP;
    end else if (count_r == '0) begin
      frame.kind = V_NONE;
    end else if (!good) begin
      frame.kind = V_DROP;
    end else if (decl_r == '0) begin
      frame.kind = V_EMPTY;
    end else begin
      frame.kind = V_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      rem_r   <= '0;
      ff_r    <= 1'b0;
      wr_r    <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      rem_r   <= rem_nxt;
      ff_r    <= ff_nxt;
      wr_r    <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    type_r <= type_nxt;
    decl_r <= decl_nxt;
    rxlo_r <= rxlo_nxt;
    rxhi_r <= rxhi_nxt;
  end
endmodule

// ----- hdl/ccfd_emit.sv -----
module ccfd_emit #(
  parameter int ENCODED_CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ccfd_pkg::frame_t                    frame,
  output logic                                in_ready,
  output logic                                ram_re,
  output logic [$clog2(ENCODED_CAPACITY)-1:0] ram_raddr,
  input  logic [ccfd_pkg::BYTE_W-1:0]         ram_rdata,
  ccfd_out_if.source                          out_chan
);
  import ccfd_pkg::*;

  localparam int AW = $clog2(ENCODED_CAPACITY);

  emit_state_t       state_r, state_nxt;
  verdict_t          kind_r, kind_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   otype_r;
  logic [LEN_W-1:0]    olen_r;
  logic [BYTE_W-1:0]   obyte_r;
  logic [IDX_W-1:0]    oidx_r;
  logic                olast_r;
  logic [DROP_W-1:0]   odrop_r;

  logic out_free;
  logic idx_last;
  logic load_single;
  logic load_byte;

  assign out_free = !out_valid_r || out_chan.ready;
  assign idx_last = (idx_r == len_r - LEN_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE: begin
        if (frame.valid) begin
          unique case (frame.kind)
            V_NONE:  state_nxt = E_IDLE;
            V_DATA:  state_nxt = E_RD;
            V_DROP,
            V_EMPTY: state_nxt = E_HOLD;
            default: state_nxt = E_IDLE;
          endcase
        end
      end
      E_HOLD: begin
        if (out_free) begin
          state_nxt = E_IDLE;
        end
      end
      E_RD: state_nxt = E_LOAD;
      E_LOAD: begin
        if (out_free) begin
          state_nxt = idx_last ? E_IDLE : E_RD;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ram_re      = 1'b0;
    load_single = 1'b0;
    load_byte   = 1'b0;
    unique case (state_r)
      E_IDLE: in_ready = 1'b1;
      E_HOLD: load_single = out_free;
      E_RD:   ram_re = 1'b1;
      E_LOAD: load_byte = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // Payload sits after the type and length bytes in the decoded buffer.
  assign ram_raddr = AW'(idx_r) + AW'(2);

  always_comb begin
    kind_nxt = kind_r;
    type_nxt = type_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    drop_nxt = drop_r;
    if (frame.valid) begin
      kind_nxt = frame.kind;
      type_nxt = frame.ftype;
      len_nxt  = frame.len;
      idx_nxt  = '0;
      if (frame.kind == V_DROP) begin
        drop_nxt = drop_r + DROP_W'(1);
      end
    end
    if (load_byte) begin
      idx_nxt = idx_r + LEN_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_single || load_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // The drop count travels with each result, since a later frame can bump the
  // counter while an earlier result still waits in the output register.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    type_r <= type_nxt;
    len_r  <= len_nxt;
    if (load_single) begin
      obyte_r <= '0;
      oidx_r  <= '0;
      olast_r <= 1'b1;
      odrop_r <= drop_r;
      if (kind_r == V_DROP) begin
        status_r <= ST_DROP;
        otype_r  <= '0;
      end else begin
        status_r <= ST_EMPTY;
        otype_r  <= type_r;
      end
      olen_r <= '0;
    end else if (load_byte) begin
      status_r <= ST_DATA;
      otype_r  <= type_r;
      olen_r   <= len_r;
      obyte_r  <= ram_rdata;
      oidx_r   <= idx_r[IDX_W-1:0];
      olast_r  <= idx_last;
      odrop_r  <= drop_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.frame_type     = otype_r;
  assign out_chan.payload_length = olen_r;
  assign out_chan.payload_byte   = obyte_r;
  assign out_chan.byte_index     = oidx_r;
  assign out_chan.last           = olast_r;
  assign out_chan.dropped_count  = odrop_r;
endmodule

// ----- hdl/cobs_crc_frame_deframer_top.sv -----
// Channel   Dir   Payload                                           Handshake
// in_chan   in    byte_in                                           valid/ready
// out_chan  out   status, frame_type, payload_length, payload_byte, valid/ready
//                 byte_index, last, dropped_count
// cfg       in    cfg_wdata (CRC initial value)                     cfg_we
//
// Encoded bytes are taken one per cycle; each is COBS-decoded and run through
// the CRC in the same cycle, and the decoded byte is written to the frame RAM.
// After a delimiter that ends a frame the input stalls: a drop or empty result
// is loaded from the hold state; each payload byte of a good frame is read from
// the RAM, then loaded into the output register, plus any out_chan.ready wait.
// Reset is synchronous and clears only control state; the RAM is not cleared.
module cobs_crc_frame_deframer_top #(
  parameter int MAX_PAYLOAD      = 32,
  parameter int ENCODED_CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ccfd_in_if.sink                    in_chan,
  ccfd_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [ccfd_pkg::CRC_W-1:0] cfg_wdata
);
  import ccfd_pkg::*;

  localparam int AW = $clog2(ENCODED_CAPACITY);

  logic [CRC_W-1:0]  crc_init_r;
  logic              in_rdy;
  logic              acc;
  frame_t            frame;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r <= 16'hFFFF;
    end else if (cfg_we) begin
      crc_init_r <= cfg_wdata;
    end
  end

  assign in_chan.ready = in_rdy;
  assign acc           = in_chan.valid && in_rdy;

  ccfd_dec #(
    .MAX_PAYLOAD      (MAX_PAYLOAD),
    .ENCODED_CAPACITY (ENCODED_CAPACITY)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .byte_in   (in_chan.byte_in),
    .crc_init  (crc_init_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .frame     (frame)
  );

  ccfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ENCODED_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ccfd_emit #(
    .ENCODED_CAPACITY (ENCODED_CAPACITY)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .in_ready  (in_rdy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_chan  (out_chan)
  );
endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import ccfd_pkg::*;

  localparam int PAYLOAD_MAX = 32;
  localparam int ENC_CAP     = 64;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 400;

  typedef logic [BYTE_W-1:0] octets_t[$];

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   ftype;
    logic [LEN_W-1:0]    plen;
    logic [BYTE_W-1:0]   pbyte;
    logic [IDX_W-1:0]    idx;
    logic                last;
    logic [DROP_W-1:0]   drops;
  } frame_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CRC_W-1:0]   cfg_wdata;

  ccfd_in_if  in_chan();
  ccfd_out_if out_chan();

  cobs_crc_frame_deframer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Deframer state as the testbench tracks it.
  logic [BYTE_W-1:0] enc_store [ENC_CAP];
  int                enc_fill;
  bit                ovf_seen;
  logic [DROP_W-1:0] drop_total;
  logic [CRC_W-1:0]  crc_seed;

  frame_result_t pending_results[$];

  bit idle_on;
  bit hold_req;
  int bytes_sent;
  int frames_sent;
  int results_due;
  int results_seen;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [CRC_W-1:0] crc_ccitt_step(input logic [CRC_W-1:0] c,
                                                      input logic [BYTE_W-1:0] d);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c  = c << 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void push_result(input frame_result_t r);
    pending_results.push_back(r);
    results_due++;
  endfunction

  // Tracks one accepted byte and queues whatever results a delimiter causes.
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] dec [ENC_CAP];
    int                rd;
    int                wr;
    int                code;
    int                decl;
    bit                ok;
    logic [CRC_W-1:0]  crc;
    logic [CRC_W-1:0]  rx;
    frame_result_t     r;
    if (b != DELIM) begin
      if (!ovf_seen) begin
        if (enc_fill >= ENC_CAP) begin
          ovf_seen = 1'b1;
        end else begin
          enc_store[enc_fill] = b;
          enc_fill++;
        end
      end
      return;
    end
    if (ovf_seen || enc_fill > 0) begin
      ok   = !ovf_seen;
      rd   = 0;
      wr   = 0;
      decl = 0;
      while (ok && rd < enc_fill) begin
        code = int'(enc_store[rd]);
        rd++;
        if (code == 0) begin
          ok = 1'b0;
        end
        for (int k = 1; ok && k < code; k++) begin
          if (rd >= enc_fill || wr >= ENC_CAP) begin
            ok = 1'b0;
          end else begin
            dec[wr] = enc_store[rd];
            wr++;
            rd++;
          end
        end
        if (ok && code != CODE_FF && rd < enc_fill) begin
          if (wr >= ENC_CAP) begin
            ok = 1'b0;
          end else begin
            dec[wr] = DELIM;
            wr++;
          end
        end
      end
      if (ok && wr < 4) begin
        ok = 1'b0;
      end
      if (ok) begin
        decl = int'(dec[1]);
        if (wr != decl + 4 || decl > PAYLOAD_MAX) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        crc = crc_seed;
        for (int i = 0; i < decl + 2; i++) begin
          crc = crc_ccitt_step(crc, dec[i]);
        end
        rx = {dec[3+decl], dec[2+decl]};
        if (rx != crc) begin
          ok = 1'b0;
        end
      end
      r      = '0;
      r.last = 1'b1;
      if (!ok) begin
        drop_total++;
        r.status = ST_DROP;
        r.drops  = drop_total;
        push_result(r);
      end else if (decl == 0) begin
        r.status = ST_EMPTY;
        r.ftype  = dec[0];
        r.drops  = drop_total;
        push_result(r);
      end else begin
        for (int i = 0; i < decl; i++) begin
          r.status = ST_DATA;
          r.ftype  = dec[0];
          r.plen   = LEN_W'(decl);
          r.pbyte  = dec[2+i];
          r.idx    = IDX_W'(i);
          r.last   = (i == decl - 1);
          r.drops  = drop_total;
          push_result(r);
        end
      end
    end
    enc_fill = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic octets_t cobs_pack(input octets_t raw);
    octets_t           enc;
    int                code_at;
    logic [BYTE_W-1:0] run;
    enc.push_back(DELIM);
    code_at = 0;
    run     = BYTE_W'(1);
    foreach (raw[i]) begin
      if (raw[i] == DELIM) begin
        enc[code_at] = run;
        code_at      = enc.size();
        enc.push_back(DELIM);
        run = BYTE_W'(1);
      end else begin
        enc.push_back(raw[i]);
        run++;
        if (run == CODE_FF) begin
          enc[code_at] = run;
          code_at      = enc.size();
          enc.push_back(DELIM);
          run = BYTE_W'(1);
        end
      end
    end
    enc[code_at] = run;
    return enc;
  endfunction

  // Decoded frame image: type, length, payload, then the CRC low byte first.
  function automatic octets_t make_frame(input logic [BYTE_W-1:0] ftype,
                                         input logic [BYTE_W-1:0] len_field,
                                         input octets_t payload, input bit spoil_crc);
    octets_t          raw;
    logic [CRC_W-1:0] crc;
    raw.push_back(ftype);
    raw.push_back(len_field);
    foreach (payload[i]) begin
      raw.push_back(payload[i]);
    end
    crc = crc_seed;
    foreach (raw[i]) begin
      crc = crc_ccitt_step(crc, raw[i]);
    end
    if (spoil_crc) begin
      crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
    end
    raw.push_back(crc[7:0]);
    raw.push_back(crc[15:8]);
    return raw;
  endfunction

  function automatic octets_t random_payload(input int n);
    octets_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        p.push_back(DELIM);
      end else begin
        p.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end
    return p;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.byte_in <= b;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_frame(input octets_t raw);
    octets_t enc;
    enc = cobs_pack(raw);
    foreach (enc[i]) begin
      send_byte(enc[i]);
    end
    send_byte(DELIM);
    frames_sent++;
  endtask

  task automatic send_good(input int n);
    octets_t p;
    p = random_payload(n);
    send_frame(make_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'(n), p, 1'b0));
  endtask

  task automatic send_nonzero_run(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(BYTE_W'($urandom_range(1, 255)));
    end
    send_byte(DELIM);
    frames_sent++;
  endtask

  // Stops offering requests and lets the block finish whatever it still holds.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_crc_seed(input logic [CRC_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    crc_seed  = v;
  endtask

  task automatic test_empty_frames();
    octets_t none;
    send_byte(DELIM);
    send_frame(make_frame(8'h5A, 8'd0, none, 1'b0));
    send_frame(make_frame(8'h00, 8'd0, none, 1'b0));
    send_frame(make_frame(8'hFF, 8'd0, none, 1'b0));
    drain();
  endtask

  task automatic test_full_payload();
    octets_t zeros;
    for (int i = 0; i < PAYLOAD_MAX; i++) begin
      zeros.push_back(8'h00);
    end
    send_frame(make_frame(8'hFF, BYTE_W'(PAYLOAD_MAX), zeros, 1'b0));
    send_frame(make_frame(8'hA5, 8'd1, random_payload(1), 1'b0));
    drain();
  endtask

  task automatic test_bad_frames();
    octets_t raw;
    send_frame(make_frame(8'h11, 8'd4, random_payload(4), 1'b1));
    raw = {8'h05};
    send_frame(raw);
    send_byte(8'h01);
    send_byte(DELIM);
    send_frame(make_frame(8'h22, 8'd5, random_payload(3), 1'b0));
    send_frame(make_frame(8'h33, BYTE_W'(PAYLOAD_MAX + 1), random_payload(PAYLOAD_MAX + 1),
                          1'b0));
    // Code byte promises more bytes than the frame holds.
    send_byte(8'h09);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(DELIM);
    drain();
  endtask

  task automatic test_overflow();
    send_nonzero_run(ENC_CAP + 1);
    send_good(2);
    drain();
  endtask

  task automatic test_crc_seeds();
    set_crc_seed(16'h0000);
    send_good(3);
    send_good(0);
    set_crc_seed(16'hFFFF);
    send_good(5);
    set_crc_seed(16'h1D0F);
    send_good(2);
    send_frame(make_frame(8'h7E, 8'd2, random_payload(2), 1'b1));
    set_crc_seed(CRC_W'($urandom_range(0, 16'hFFFF)));
    send_good(4);
    drain();
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++) begin
      send_good(6);
    end
    drain();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int n_results);
    int                bytes_start;
    int                res_start;
    bit                seed_moved;
    int                len;
    int                pick;
    octets_t           raw;
    logic [BYTE_W-1:0] len_field;
    bytes_start = bytes_sent;
    res_start   = results_due;
    seed_moved  = 1'b0;
    while (bytes_sent - bytes_start < n_bytes || results_due - res_start < n_results) begin
      if (!seed_moved && bytes_sent - bytes_start > n_bytes / 2) begin
        set_crc_seed(CRC_W'($urandom_range(0, 16'hFFFF)));
        seed_moved = 1'b1;
      end
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAYLOAD_MAX)
                                         : $urandom_range(0, 6);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        send_good(len);
      end else if (pick < 15) begin
        send_frame(make_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'(len),
                              random_payload(len), 1'b1));
      end else if (pick < 16) begin
        len_field = ($urandom_range(0, 1) == 0) ? BYTE_W'(len + $urandom_range(1, 3))
                                                : BYTE_W'($urandom_range(PAYLOAD_MAX + 1, 255));
        send_frame(make_frame(BYTE_W'($urandom_range(0, 255)), len_field,
                              random_payload(len), 1'b0));
      end else if (pick < 17) begin
        // Encoded frame with its tail cut off.
        raw = cobs_pack(make_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'(len),
                                   random_payload(len), 1'b0));
        repeat ($urandom_range(1, 2)) void'(raw.pop_back());
        foreach (raw[i]) begin
          send_byte(raw[i]);
        end
        send_byte(DELIM);
        frames_sent++;
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 10)) send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(DELIM);
      end else if ($urandom_range(0, 2) == 0) begin
        send_nonzero_run($urandom_range(ENC_CAP + 1, ENC_CAP + 8));
      end else begin
        send_byte(DELIM);
      end
    end
    drain();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    for (int i = 0; i < 3; i++) begin
      send_good($urandom_range(0, 6));
    end
    send_frame(make_frame(8'h44, 8'd3, random_payload(3), 1'b1));
    drain();
  endtask

  // Receiver side: random stalls, plus one long hold when a test asks for it.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic void report_mismatch(input string what, input frame_result_t want,
                                          input frame_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s at %0t", what, $realtime);
      $display("  exp status=%0d type=%02h len=%0d byte=%02h idx=%0d last=%0b drops=%0d",
               want.status, want.ftype, want.plen, want.pbyte, want.idx, want.last,
               want.drops);
      $display("  got status=%0d type=%02h len=%0d byte=%02h idx=%0d last=%0b drops=%0d",
               got.status, got.ftype, got.plen, got.pbyte, got.idx, got.last, got.drops);
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.status = out_chan.status;
      got.ftype  = out_chan.frame_type;
      got.plen   = out_chan.payload_length;
      got.pbyte  = out_chan.payload_byte;
      got.idx    = out_chan.byte_index;
      got.last   = out_chan.last;
      got.drops  = out_chan.dropped_count;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.ftype !== want.ftype ||
            got.plen !== want.plen || got.pbyte !== want.pbyte ||
            got.idx !== want.idx || got.last !== want.last ||
            got.drops !== want.drops) begin
          report_mismatch("result field", want, got);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("cobs_crc_frame_deframer_top verification failed");
    $finish;
  end

  initial begin
    in_chan.valid   <= 1'b0;
    in_chan.byte_in <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    enc_fill     = 0;
    ovf_seen     = 1'b0;
    drop_total   = '0;
    crc_seed     = 16'hFFFF;
    bytes_sent   = 0;
    frames_sent  = 0;
    results_due  = 0;
    results_seen = 0;
    mismatches   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_frames();
    test_full_payload();
    test_bad_frames();
    test_overflow();
    test_crc_seeds();
    test_backpressure();
    test_random_traffic(40, 8);
    test_steady_stream();

    $display("Sent %0d bytes in %0d frames; checked %0d results, %0d of them drops",
             bytes_sent, frames_sent, results_seen, drop_total);
    $display("Covered empty, full, malformed, overflowed and bad-CRC frames over 6 CRC seeds");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("cobs_crc_frame_deframer_top verification clean");
    end else begin
      $display("cobs_crc_frame_deframer_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ccfd_pkg.sv
hdl/ccfd_in_if.sv
hdl/ccfd_out_if.sv
hdl/ccfd_ram.sv
hdl/ccfd_dec.sv
hdl/ccfd_emit.sv
hdl/cobs_crc_frame_deframer_top.sv
test/tb_top.sv
